/* src/jdc_pkg.sv */
// Shared constants for the Julian day to calendar date unit.
package jdc_pkg;

  // Pipeline depth of both the date path and the time-of-day path.
  localparam int unsigned NUM_STAGES = 10;

  // Port field widths.
  localparam int unsigned JDN_W    = 23;
  localparam int unsigned YEAR_W   = 15;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;

  // Width of a whole-minute count within one day.
  localparam int unsigned MINUTES_W = 11;

  // Fliegel-Van Flandern constants.
  localparam int unsigned JDN_OFFSET      = 68569;
  localparam int unsigned DAYS_PER_400Y   = 146097;
  localparam int unsigned YEAR_SCALE      = 4000;
  localparam int unsigned YEAR_DIVISOR    = 1461001;
  localparam int unsigned DAYS_PER_4Y     = 1461;
  localparam int unsigned MONTH_DIVISOR   = 2447;
  localparam int unsigned MONTH_SCALE     = 80;
  localparam int unsigned MONTHS_CARRY    = 11;
  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned DAY_BIAS        = 31;
  localparam int unsigned CENTURY_BIAS    = 49;
  localparam int unsigned YEARS_PER_CENT  = 100;

  // Time of day constants.
  localparam int unsigned MINUTES_PER_DAY  = 1440;
  localparam int unsigned MINUTES_PER_HOUR = 60;

endpackage

/* src/jdc_cdiv.sv */
// Registered floor division of an unsigned value by a constant via reciprocal multiply.
module jdc_cdiv #(
  parameter int unsigned IN_W    = 8,
  parameter int unsigned DIVISOR = 3,
  parameter int unsigned OUT_W   = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IN_W-1:0]  x_i,
  output logic [OUT_W-1:0] q_o
);

  // With SHIFT = IN_W + clog2(DIVISOR) and a rounded-up reciprocal, the
  // product's upper bits equal the exact floor quotient for every input.
  localparam int unsigned DIV_BITS = $clog2(DIVISOR);
  localparam int unsigned SHIFT    = IN_W + DIV_BITS;
  localparam int unsigned MULT_W   = IN_W + 1;
  localparam int unsigned PROD_W   = IN_W + MULT_W;
  localparam longint unsigned MULT =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MULT_W-1:0] MULT_C = MULT_W'(MULT);

  logic [PROD_W-1:0] prod;
  logic [OUT_W-1:0]  q_d;
  logic [OUT_W-1:0]  q_q;

  assign prod = PROD_W'(x_i) * PROD_W'(MULT_C);
  assign q_d  = prod[SHIFT +: OUT_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

/* src/jdc_date.sv */
// Date path: day number to year, month and day of month.
module jdc_date import jdc_pkg::*; (
  input  logic                     clk_i,
  input  logic [NUM_STAGES-1:0]    en_i,
  input  logic [JDN_W-1:0]         jdn_i,
  output logic signed [YEAR_W-1:0] year_o,
  output logic [MONTH_W-1:0]       month_o,
  output logic [DAY_W-1:0]         day_o
);

  // Stage 0: offset day number and century count.
  logic [23:0] a_d;
  logic [23:0] a_s0_q;
  logic [7:0]  cent_s0;

  assign a_d = 24'(jdn_i) + 24'(JDN_OFFSET);

  jdc_cdiv #(.IN_W(26), .DIVISOR(DAYS_PER_400Y), .OUT_W(8)) u_cent (
    .clk_i (clk_i),
    .en_i  (en_i[0]),
    .x_i   ({a_d, 2'b00}),
    .q_o   (cent_s0)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_s0_q <= a_d;
    end
  end

  // Stage 1: day within the century.
  logic [25:0] cent_days;
  logic [25:0] cent_sum;
  logic [15:0] b_d;
  logic [15:0] b_s1_q;
  logic [7:0]  cent_s1_q;

  assign cent_days = 26'(cent_s0) * 26'(DAYS_PER_400Y);
  assign cent_sum  = cent_days + 26'd3;
  assign b_d       = 16'(a_s0_q - 24'(cent_sum >> 2));

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      b_s1_q    <= b_d;
      cent_s1_q <= cent_s0;
    end
  end

  // Stage 2: scale for the year-in-century division.
  logic [27:0] x2_d;
  logic [27:0] x2_s2_q;
  logic [15:0] b_s2_q;
  logic [7:0]  cent_s2_q;

  assign x2_d = 28'(YEAR_SCALE) * (28'(b_s1_q) + 28'd1);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      x2_s2_q   <= x2_d;
      b_s2_q    <= b_s1_q;
      cent_s2_q <= cent_s1_q;
    end
  end

  // Stage 3: year within the century.
  logic [6:0]  yr4_s3;
  logic [15:0] b_s3_q;
  logic [7:0]  cent_s3_q;

  jdc_cdiv #(.IN_W(28), .DIVISOR(YEAR_DIVISOR), .OUT_W(7)) u_yr4 (
    .clk_i (clk_i),
    .en_i  (en_i[3]),
    .x_i   (x2_s2_q),
    .q_o   (yr4_s3)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      b_s3_q    <= b_s2_q;
      cent_s3_q <= cent_s2_q;
    end
  end

  // Stage 4: day of the year counted from March, plus bias.
  logic [17:0] yr4_days;
  logic [9:0]  c_d;
  logic [9:0]  c_s4_q;
  logic [6:0]  yr4_s4_q;
  logic [7:0]  cent_s4_q;

  assign yr4_days = 18'(yr4_s3) * 18'(DAYS_PER_4Y);
  assign c_d      = 10'(18'(b_s3_q) - (yr4_days >> 2) + 18'(DAY_BIAS));

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      c_s4_q    <= c_d;
      yr4_s4_q  <= yr4_s3;
      cent_s4_q <= cent_s3_q;
    end
  end

  // Stage 5: scale for the month division.
  logic [16:0] x3_d;
  logic [16:0] x3_s5_q;
  logic [9:0]  c_s5_q;
  logic [6:0]  yr4_s5_q;
  logic [7:0]  cent_s5_q;

  assign x3_d = 17'(c_s4_q) * 17'(MONTH_SCALE);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      x3_s5_q   <= x3_d;
      c_s5_q    <= c_s4_q;
      yr4_s5_q  <= yr4_s4_q;
      cent_s5_q <= cent_s4_q;
    end
  end

  // Stage 6: month index counted from March.
  logic [5:0] mq_s6;
  logic [9:0] c_s6_q;
  logic [6:0] yr4_s6_q;
  logic [7:0] cent_s6_q;

  jdc_cdiv #(.IN_W(17), .DIVISOR(MONTH_DIVISOR), .OUT_W(6)) u_mq (
    .clk_i (clk_i),
    .en_i  (en_i[6]),
    .x_i   (x3_s5_q),
    .q_o   (mq_s6)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      c_s6_q    <= c_s5_q;
      yr4_s6_q  <= yr4_s5_q;
      cent_s6_q <= cent_s5_q;
    end
  end

  // Stage 7: days before the month, and the year carry for January and February.
  logic [16:0] y_d;
  logic [16:0] y_s7_q;
  logic [5:0]  mq_s7_q;
  logic [9:0]  c_s7_q;
  logic [6:0]  yr4_s7_q;
  logic [7:0]  cent_s7_q;
  logic [1:0]  carry_s7;

  assign y_d = 17'(mq_s6) * 17'(MONTH_DIVISOR);

  jdc_cdiv #(.IN_W(6), .DIVISOR(MONTHS_CARRY), .OUT_W(2)) u_carry (
    .clk_i (clk_i),
    .en_i  (en_i[7]),
    .x_i   (mq_s6),
    .q_o   (carry_s7)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      y_s7_q    <= y_d;
      mq_s7_q   <= mq_s6;
      c_s7_q    <= c_s6_q;
      yr4_s7_q  <= yr4_s6_q;
      cent_s7_q <= cent_s6_q;
    end
  end

  // Stage 8: whole days before the month.
  logic [9:0] qd_s8;
  logic [5:0] mq_s8_q;
  logic [9:0] c_s8_q;
  logic [6:0] yr4_s8_q;
  logic [7:0] cent_s8_q;
  logic [1:0] carry_s8_q;

  jdc_cdiv #(.IN_W(17), .DIVISOR(MONTH_SCALE), .OUT_W(10)) u_qd (
    .clk_i (clk_i),
    .en_i  (en_i[8]),
    .x_i   (y_s7_q),
    .q_o   (qd_s8)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      mq_s8_q    <= mq_s7_q;
      c_s8_q     <= c_s7_q;
      yr4_s8_q   <= yr4_s7_q;
      cent_s8_q  <= cent_s7_q;
      carry_s8_q <= carry_s7;
    end
  end

  // Stage 9: final date fields, kept modulo their field widths.
  logic [9:0]         dom_full;
  logic [7:0]         mon_full;
  logic signed [15:0] yr_full;
  logic signed [YEAR_W-1:0] year_d;
  logic [MONTH_W-1:0] month_d;
  logic [DAY_W-1:0]   day_d;
  logic signed [YEAR_W-1:0] year_q;
  logic [MONTH_W-1:0] month_q;
  logic [DAY_W-1:0]   day_q;

  assign dom_full = c_s8_q - qd_s8;
  assign mon_full = 8'(mq_s8_q) + 8'd2 - 8'(MONTHS_PER_YEAR) * 8'(carry_s8_q);
  assign yr_full  = 16'(YEARS_PER_CENT) * ($signed({8'b0, cent_s8_q}) - 16'(CENTURY_BIAS))
                  + $signed({9'b0, yr4_s8_q}) + $signed({14'b0, carry_s8_q});

  assign year_d  = yr_full[YEAR_W-1:0];
  assign month_d = mon_full[MONTH_W-1:0];
  assign day_d   = dom_full[DAY_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

/* src/jdc_time.sv */
// Time path: day fraction to hour and minute, delayed to match the date path.
module jdc_time import jdc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic [NUM_STAGES-1:0]    en_i,
  input  logic [FRACTION_BITS-1:0] frac_i,
  output logic [HOUR_W-1:0]        hour_o,
  output logic [MINUTE_W-1:0]      minute_o
);

  localparam int unsigned PROD_W = FRACTION_BITS + MINUTES_W;

  // Stage 0: whole minutes since midnight, truncated.
  logic [PROD_W-1:0]    scaled;
  logic [MINUTES_W-1:0] mins_d;
  logic [MINUTES_W-1:0] mins_s0_q;

  assign scaled = PROD_W'(frac_i) * PROD_W'(MINUTES_PER_DAY);
  assign mins_d = scaled[FRACTION_BITS +: MINUTES_W];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mins_s0_q <= mins_d;
    end
  end

  // Stage 1: hour.
  logic [HOUR_W-1:0]    hr_s1;
  logic [MINUTES_W-1:0] mins_s1_q;

  jdc_cdiv #(.IN_W(MINUTES_W), .DIVISOR(MINUTES_PER_HOUR), .OUT_W(HOUR_W)) u_hour (
    .clk_i (clk_i),
    .en_i  (en_i[1]),
    .x_i   (mins_s0_q),
    .q_o   (hr_s1)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mins_s1_q <= mins_s0_q;
    end
  end

  // Stage 2 computes the minute; later stages only delay both fields.
  logic [MINUTES_W-1:0] hr_mins;
  logic [MINUTE_W-1:0]  mn_d;
  logic [HOUR_W-1:0]    hr_q [2:NUM_STAGES-1];
  logic [MINUTE_W-1:0]  mn_q [2:NUM_STAGES-1];

  assign hr_mins = MINUTES_W'(hr_s1) * MINUTES_W'(MINUTES_PER_HOUR);
  assign mn_d    = MINUTE_W'(mins_s1_q - hr_mins);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      hr_q[2] <= hr_s1;
      mn_q[2] <= mn_d;
    end
  end

  for (genvar k = 3; k < NUM_STAGES; k++) begin : g_delay
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        hr_q[k] <= hr_q[k-1];
        mn_q[k] <= mn_q[k-1];
      end
    end
  end

  assign hour_o   = hr_q[NUM_STAGES-1];
  assign minute_o = mn_q[NUM_STAGES-1];

endmodule

/* src/julian_day_to_calendar_date_unit.sv */
// Top level of the Julian day to calendar date unit: pipeline control and datapaths.
//
//   Channel  Direction  Handshake          Payload
//   input    in         valid_i / stall_o  julian_day_number_i, day_fraction_i
//   output   out        valid_o / stall_i  year_o, month_o, day_o, hour_o, minute_o
//
// Accepts one item per cycle while stall_o is low; each item passes through
// the ten register stages of the date path before its result is presented on
// the output (constant reciprocal multiplies and constant multiply-and-adds
// spread over the stages).
// Reset clears only the stage valid bits; the datapath registers are not reset.
// A held output stalls only the stages behind it that hold items, so empty
// stages keep filling and stall_o rises only when every stage is occupied.
module julian_day_to_calendar_date_unit import jdc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [JDN_W-1:0]         julian_day_number_i,
  input  logic [FRACTION_BITS-1:0] day_fraction_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [YEAR_W-1:0] year_o,
  output logic [MONTH_W-1:0]       month_o,
  output logic [DAY_W-1:0]         day_o,
  output logic [HOUR_W-1:0]        hour_o,
  output logic [MINUTE_W-1:0]      minute_o
);

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES:0]   ready;

  // A stage may load when it is empty or the stage after it moves on.
  assign ready[NUM_STAGES] = !stall_i;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ready
    assign ready[k] = !valid_q[k] || ready[k+1];
  end

  always_comb begin
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stall_o = !ready[0];
  assign valid_o = valid_q[NUM_STAGES-1];

  jdc_date u_date (
    .clk_i   (clk_i),
    .en_i    (ready[NUM_STAGES-1:0]),
    .jdn_i   (julian_day_number_i),
    .year_o  (year_o),
    .month_o (month_o),
    .day_o   (day_o)
  );

  jdc_time #(.FRACTION_BITS(FRACTION_BITS)) u_time (
    .clk_i    (clk_i),
    .en_i     (ready[NUM_STAGES-1:0]),
    .frac_i   (day_fraction_i),
    .hour_o   (hour_o),
    .minute_o (minute_o)
  );

  // The first stage can only be blocked by a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !stall_i |-> !stall_o)
    else $error("input stalled while output is not stalled");

  // An accepted item occupies the first stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> valid_q[0])
    else $error("accepted item lost at pipeline entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12))
    else $error("month out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (day_o != 5'd0))
    else $error("day of month is zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hour_o <= 5'd23 && minute_o <= 6'd59))
    else $error("time of day out of range");

endmodule

/* sim/jdc_checker.sv */
// Checker for the Julian day to calendar date unit: predicts each date and compares results.
module jdc_checker import jdc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [JDN_W-1:0]         julian_day_number_i,
  input  logic [FRACTION_BITS-1:0] day_fraction_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [YEAR_W-1:0] year_i,
  input  logic [MONTH_W-1:0]       month_i,
  input  logic [DAY_W-1:0]         day_i,
  input  logic [HOUR_W-1:0]        hour_i,
  input  logic [MINUTE_W-1:0]      minute_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [JDN_W-1:0]         jdn;
    logic [FRACTION_BITS-1:0] fraction;
    logic [YEAR_W-1:0]        year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic [HOUR_W-1:0]        hour;
    logic [MINUTE_W-1:0]      minute;
  } calendar_date_t;

  calendar_date_t expected_dates[$];
  int unsigned    mismatches = 0;

  // Every intermediate that is divided stays non-negative for a 23-bit day number,
  // so plain division is floor division here.
  function automatic calendar_date_t convert_day(input logic [JDN_W-1:0] jdn,
                                                 input logic [FRACTION_BITS-1:0] fraction);
    calendar_date_t     date;
    longint             shifted;
    longint             centuries;
    longint             day_of_era;
    longint             year_of_era;
    longint             day_of_year;
    longint             month_index;
    longint             year_carry;
    longint             day_of_month;
    longint             month_num;
    longint             year_num;
    longint unsigned    minutes;
    longint unsigned    hours;
    longint unsigned    minute_num;
    shifted      = longint'(jdn) + 68569;
    centuries    = (4 * shifted) / 146097;
    day_of_era   = shifted - (146097 * centuries + 3) / 4;
    year_of_era  = (4000 * (day_of_era + 1)) / 1461001;
    day_of_year  = day_of_era - (1461 * year_of_era) / 4 + 31;
    month_index  = (80 * day_of_year) / 2447;
    day_of_month = day_of_year - (2447 * month_index) / 80;
    year_carry   = month_index / 11;
    month_num    = month_index + 2 - 12 * year_carry;
    year_num     = 100 * (centuries - 49) + year_of_era + year_carry;
    minutes      = (longint'(fraction) * 1440) >> FRACTION_BITS;
    hours        = minutes / 60;
    minute_num   = minutes % 60;
    date.jdn      = jdn;
    date.fraction = fraction;
    date.year     = year_num[YEAR_W-1:0];
    date.month    = month_num[MONTH_W-1:0];
    date.day      = day_of_month[DAY_W-1:0];
    date.hour     = hours[HOUR_W-1:0];
    date.minute   = minute_num[MINUTE_W-1:0];
    return date;
  endfunction

  always @(posedge clk_i) begin
    calendar_date_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        expected_dates.push_back(convert_day(julian_day_number_i, day_fraction_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          if (mismatches < 10) begin
            $display("ERROR %0t: result %0d-%0d-%0d %0d:%0d with no item outstanding",
                     $realtime, year_i, month_i, day_i, hour_i, minute_i);
          end
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          if (year_i !== want.year || month_i !== want.month || day_i !== want.day ||
              hour_i !== want.hour || minute_i !== want.minute) begin
            if (mismatches < 10) begin
              $display("ERROR %0t: jdn %0d fraction %0d: expected %0d-%0d-%0d %0d:%0d,",
                       $realtime, want.jdn, want.fraction,
                       $signed(want.year), want.month, want.day, want.hour, want.minute,
                       " got %0d-%0d-%0d %0d:%0d",
                       year_i, month_i, day_i, hour_i, minute_i);
            end
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_dates.size();
    end
  end

endmodule

/* sim/testbench.sv */
// Top of the testbench: clock, reset, stimulus, output stalls, watchdog and verdict.
module testbench import jdc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRACTION_BITS  = 16;
  localparam int unsigned LAST_VALID_JDN = 5373484;
  localparam int unsigned RANDOM_ITEMS   = 1700;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     valid_i;
  logic                     stall_o;
  logic [JDN_W-1:0]         julian_day_number_i;
  logic [FRACTION_BITS-1:0] day_fraction_i;
  logic                     valid_o;
  logic                     stall_i = 1'b0;
  logic signed [YEAR_W-1:0] year_o;
  logic [MONTH_W-1:0]       month_o;
  logic [DAY_W-1:0]         day_o;
  logic [HOUR_W-1:0]        hour_o;
  logic [MINUTE_W-1:0]      minute_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  bit          idle_on;
  int          stall_left = 0;
  int unsigned quiet_cycles = 0;

  julian_day_to_calendar_date_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (valid_i),
    .stall_o             (stall_o),
    .julian_day_number_i (julian_day_number_i),
    .day_fraction_i      (day_fraction_i),
    .valid_o             (valid_o),
    .stall_i             (stall_i),
    .year_o              (year_o),
    .month_o             (month_o),
    .day_o               (day_o),
    .hour_o              (hour_o),
    .minute_o            (minute_o)
  );

  jdc_checker #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (valid_i),
    .in_stall_i          (stall_o),
    .julian_day_number_i (julian_day_number_i),
    .day_fraction_i      (day_fraction_i),
    .out_valid_i         (valid_o),
    .out_stall_i         (stall_i),
    .year_i              (year_o),
    .month_i             (month_o),
    .day_i               (day_o),
    .hour_i              (hour_o),
    .minute_i            (minute_o),
    .mismatch_count_o    (mismatch_count),
    .pending_count_o     (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output stalls come in random bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (!idle_on) begin
      stall_left = 0;
      stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Day number of January 1 of a proleptic Gregorian year, for years from 1.
  function automatic int unsigned new_year_jdn(input int unsigned year_num);
    int unsigned prior;
    prior = year_num - 1;
    return 1721426 + 365 * prior + prior / 4 - prior / 100 + prior / 400;
  endfunction

  function automatic logic [JDN_W-1:0] pick_day_number();
    int unsigned base;
    case ($urandom_range(0, 19))
      0, 1, 2: return JDN_W'($urandom_range(0, (1 << JDN_W) - 1));
      3, 4, 5, 6, 7: begin
        // Land on a year turn or on the end of February.
        base = new_year_jdn($urandom_range(1, 9999));
        if ($urandom_range(0, 1) == 0) begin
          return JDN_W'(base + $urandom_range(0, 6) - 3);
        end else begin
          return JDN_W'(base + $urandom_range(56, 61));
        end
      end
      default: return JDN_W'($urandom_range(0, LAST_VALID_JDN));
    endcase
  endfunction

  function automatic logic [FRACTION_BITS-1:0] pick_fraction();
    longint unsigned minute_num;
    case ($urandom_range(0, 9))
      0, 1: begin
        // Straddle a minute boundary, where truncation decides the minute.
        minute_num = $urandom_range(0, 1439);
        return FRACTION_BITS'(((minute_num << FRACTION_BITS) / 1440) +
                              $urandom_range(0, 1));
      end
      2: return FRACTION_BITS'((1 << FRACTION_BITS) - 1 - $urandom_range(0, 3));
      default: return FRACTION_BITS'($urandom_range(0, (1 << FRACTION_BITS) - 1));
    endcase
  endfunction

  task automatic send_item(input logic [JDN_W-1:0] jdn,
                           input logic [FRACTION_BITS-1:0] fraction);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    valid_i             <= 1'b1;
    julian_day_number_i <= jdn;
    day_fraction_i      <= fraction;
    do @(posedge clk_i); while (stall_o);
  endtask

  initial begin
    int unsigned item;
    rst_ni              = 1'b0;
    valid_i             = 1'b0;
    julian_day_number_i = '0;
    day_fraction_i      = '0;
    idle_on             = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes, calendar corners and the year wrap past 16383.
    send_item(23'd0, 16'd0);
    send_item(23'd0, 16'hFFFF);
    send_item(JDN_W'(LAST_VALID_JDN), 16'hFFFF);
    send_item(23'h7FFFFF, 16'hFFFF);
    send_item(23'h7FFFFF, 16'd0);
    send_item(23'd2451545, 16'h8000);
    send_item(23'd2451603, 16'h5555);
    send_item(23'd2451604, 16'hAAAA);
    send_item(23'd2451605, 16'd45);
    send_item(23'd2415079, 16'd46);
    send_item(23'd2415080, 16'd2730);
    send_item(23'd2299160, 16'd2731);
    send_item(23'd2299161, 16'd1);
    send_item(23'd1721057, 16'd65490);
    send_item(23'd1721058, 16'd65489);
    send_item(23'd1721425, 16'h0F0F);
    send_item(23'd1721426, 16'hF0F0);
    send_item(23'd7705192, 16'h7FFF);
    send_item(23'd7705193, 16'h8001);
    send_item(23'h400000, 16'h3FFF);

    for (item = 0; item < RANDOM_ITEMS; item++) begin
      idle_on = (item < 600) || (item >= 1000 && item < 1400);
      send_item(pick_day_number(), pick_fraction());
    end

    @(negedge clk_i);
    valid_i <= 1'b0;
    idle_on = 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
src/jdc_pkg.sv
src/jdc_cdiv.sv
src/jdc_date.sv
src/jdc_time.sv
src/julian_day_to_calendar_date_unit.sv
sim/jdc_checker.sv
sim/testbench.sv
